[rtl/atp_pkg.sv]
// Shared types and constants for the ANSI text terminal parser.
// No dependencies.
package atp_pkg;

    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_BRACKET   = 8'h5B;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_FINAL     = 8'h6D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [3:0] DIGIT_EMPTY  = 4'd15;

    localparam logic [1:0] CFG_COLS  = 2'd0;
    localparam logic [1:0] CFG_ROWS  = 2'd1;
    localparam logic [1:0] CFG_DFORE = 2'd2;
    localparam logic [1:0] CFG_DBACK = 2'd3;

    localparam int TDATA_OUT_W = 80;

    typedef enum logic [2:0] {
        OP_PRINT = 3'b001,
        OP_BACK  = 3'b010,
        OP_LINE  = 3'b100
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] code;
        logic [23:0] fore;
        logic [23:0] back;
    } t_cmd;

    function automatic logic [23:0] palette(input logic [2:0] idx);
        logic [23:0] c;
        c = {{8{idx[0]}}, {8{idx[1]}}, {8{idx[2]}}};
        return c;
    endfunction

endpackage

[rtl/ansi_text_terminal_parser.sv]
// Top level of the ANSI text terminal parser: config registers, front, back.
// Depends on atp_pkg, atp_front, atp_back.
//
// channel   direction  fields
// s_axis    in         tdata: code[7:0]
// m_axis    out        tdata: kind, col, row, glyph, fore, back; tlast: last
// cfg       in         0 cols, 1 rows, 2 fg_default, 3 bg_default
//
// A printable, newline or backspace item is accepted in S_IN, then handed off from S_CMD, where it waits for the back.
// ESC, '[', digits and ';' are consumed in S_IN alone; an 'm' then enters S_WALK, which applies a 38/48 color
// at once, otherwise walks the arguments one by one, up to MAX_ARGS.
// The back registers each result; a cell write that causes a scroll is followed by a separate scroll result.
// Reset is synchronous; while the front holds a command for the back, it does not accept input.
module ansi_text_terminal_parser #(
    parameter int MAX_ARGS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [atp_pkg::TDATA_OUT_W-1:0] m_axis_tdata, // kind,col,row,glyph,fore,back
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import atp_pkg::*;

    logic [7:0]  r_cols, r_rows;
    logic [23:0] r_dfore, r_dback;
    logic        w_cv, w_cr;
    t_cmd        w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 8'd80;
            r_rows <= 8'd25;
            r_dfore <= 24'hFFFFFF;
            r_dback <= 24'h000000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLS:  r_cols <= i_cfg_data[7:0];
                CFG_ROWS:  r_rows <= i_cfg_data[7:0];
                CFG_DFORE: r_dfore <= i_cfg_data;
                CFG_DBACK: r_dback <= i_cfg_data;
                default: ;
            endcase
        end
    end

    atp_front #(.MAX_ARGS(MAX_ARGS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_code(s_axis_tdata),
        .i_dfore(r_dfore), .i_dback(r_dback),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    atp_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .i_item(s_axis_tvalid & s_axis_tready),
        .i_cols(r_cols), .i_rows(r_rows),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule

[rtl/atp_front.sv]
// Front end: escape/SGR parser and color state; emits cursor commands.
// Depends on atp_pkg.
module atp_front #(
    parameter int MAX_ARGS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_code,
    input  logic [23:0]        i_dfore,
    input  logic [23:0]        i_dback,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output atp_pkg::t_cmd      o_cmd
);
    import atp_pkg::*;

    localparam int AW = $clog2(MAX_ARGS);

    typedef enum logic [2:0] {
        S_IN   = 3'b001,
        S_WALK = 3'b010,
        S_CMD  = 3'b100
    } t_state;

    t_state      r_state;
    logic        r_esc, r_seq;
    logic [AW-1:0] r_slot, r_walk;
    logic [1:0]  r_dig;
    logic [3:0]  r_args [MAX_ARGS][3];
    logic [23:0] r_fore, r_back;
    t_cmd        r_cmd;
    logic [9:0]  r_v0, r_v1, r_v2, r_v3, r_v4;

    function automatic logic [9:0] argval(input logic [3:0] d0, input logic [3:0] d1,
                                          input logic [3:0] d2);
        logic [9:0] v;
        v = 10'd0;
        if (d0 <= 4'd9) begin
            v = {6'd0, d0};
            if (d1 <= 4'd9) begin
                v = 10'(v * 10 + d1);
                if (d2 <= 4'd9) v = 10'(v * 10 + d2);
            end
        end
        return v;
    endfunction

    logic [9:0] w_wv;
    logic       w_digit, w_plain;
    logic [7:0] w_cv;
    assign w_wv    = argval(r_args[r_walk][0], r_args[r_walk][1], r_args[r_walk][2]);
    assign w_digit = i_code >= 8'h30 && i_code <= 8'h39;
    assign w_cv    = i_code - 8'h30;
    assign o_ready = r_state == S_IN;
    assign o_cmd_valid = r_state == S_CMD;
    assign o_cmd   = r_cmd;

    always_comb begin
        w_plain = 1'b1;
        if (r_seq) begin
            if (w_digit || i_code == CH_SEMI || i_code == CH_FINAL) w_plain = 1'b0;
        end else if (r_esc) begin
            if (i_code == CH_BRACKET || i_code == CH_ESC) w_plain = 1'b0;
        end
        if (i_code == CH_ESC) w_plain = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_esc <= 1'b0;
            r_seq <= 1'b0;
            r_slot <= '0;
            r_dig <= '0;
            r_walk <= '0;
            r_fore <= 24'hFFFFFF;
            r_back <= 24'h000000;
            for (int a = 0; a < MAX_ARGS; a++)
                for (int k = 0; k < 3; k++) r_args[a][k] <= DIGIT_EMPTY;
        end else begin
            unique case (r_state)
                S_IN: if (i_valid) begin
                    if (r_seq && w_digit) begin
                        r_args[r_slot][r_dig] <= w_cv[3:0];
                        r_dig <= (r_dig == 2'd2) ? 2'd0 : r_dig + 2'd1;
                    end else if (r_seq && i_code == CH_SEMI) begin
                        if (32'(r_slot) < MAX_ARGS - 1) r_slot <= r_slot + 1'b1;
                        r_dig <= '0;
                    end else if (r_seq && i_code == CH_FINAL) begin
                        r_seq <= 1'b0;
                        r_esc <= 1'b0;
                        r_dig <= '0;
                        r_walk <= '0;
                        r_v0 <= argval(r_args[0][0], r_args[0][1], r_args[0][2]);
                        r_v1 <= argval(r_args[1][0], r_args[1][1], r_args[1][2]);
                        r_v2 <= argval(r_args[2][0], r_args[2][1], r_args[2][2]);
                        r_v3 <= argval(r_args[3][0], r_args[3][1], r_args[3][2]);
                        r_v4 <= argval(r_args[4][0], r_args[4][1], r_args[4][2]);
                        r_state <= S_WALK;
                    end else if (!r_seq && r_esc && i_code == CH_BRACKET) begin
                        r_seq <= 1'b1;
                        r_slot <= '0;
                        r_dig <= '0;
                        for (int a = 0; a < MAX_ARGS; a++)
                            for (int k = 0; k < 3; k++) r_args[a][k] <= DIGIT_EMPTY;
                    end else begin
                        r_seq <= 1'b0;
                        r_dig <= r_seq ? 2'd0 : r_dig;
                        r_esc <= i_code == CH_ESC;
                        if (w_plain) begin
                            r_cmd.op <= (i_code == CH_NEWLINE) ? OP_LINE :
                                        (i_code == CH_BACKSPACE) ? OP_BACK : OP_PRINT;
                            r_cmd.code <= i_code;
                            r_cmd.fore <= r_fore;
                            r_cmd.back <= r_back;
                            r_state <= S_CMD;
                        end
                    end
                end
                S_WALK: begin
                    if (r_v0 == 10'd38 || r_v0 == 10'd48) begin
                        if (32'(r_slot) == 4 && r_v1 == 10'd2 && r_v2 <= 10'd255 &&
                            r_v3 <= 10'd255 && r_v4 <= 10'd255) begin
                            if (r_v0 == 10'd38)
                                r_fore <= {r_v2[7:0], r_v3[7:0], r_v4[7:0]};
                            else
                                r_back <= {r_v2[7:0], r_v3[7:0], r_v4[7:0]};
                        end
                        r_state <= S_IN;
                    end else begin
                        if (w_wv >= 10'd30 && w_wv <= 10'd37)
                            r_fore <= palette(w_wv[2:0] - 3'd6);
                        else if (w_wv >= 10'd40 && w_wv <= 10'd47)
                            r_back <= palette(w_wv[2:0]);
                        else if (w_wv == 10'd39)
                            r_fore <= i_dfore;
                        else if (w_wv == 10'd49)
                            r_back <= i_dback;
                        else begin
                            r_fore <= i_dfore;
                            r_back <= i_dback;
                        end
                        if (r_walk == r_slot) r_state <= S_IN;
                        r_walk <= r_walk + 1'b1;
                    end
                end
                S_CMD: if (i_cmd_ready) r_state <= S_IN;
                default: r_state <= S_IN;
            endcase
        end
    end
endmodule

[rtl/atp_back.sv]
// Back end: cursor tracking, wrap and scroll; emits cell writes and scroll results.
// Depends on atp_pkg.
module atp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  atp_pkg::t_cmd       i_cmd,
    input  logic                i_item,
    input  logic [7:0]          i_cols,
    input  logic [7:0]          i_rows,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [atp_pkg::TDATA_OUT_W-1:0] o_data,
    output logic                o_last
);
    import atp_pkg::*;

    logic [7:0] r_col, r_row;
    logic       r_valid, r_last, r_scroll_pend;
    logic [TDATA_OUT_W-1:0] r_data;
    logic [7:0] w_w, w_h, w_c, w_r, w_nc, w_nr;
    logic [8:0] w_c1;
    logic       w_scroll, w_emit;

    assign w_w = (i_cols == 8'd0) ? 8'd1 : i_cols;
    assign w_h = (i_rows == 8'd0) ? 8'd1 : i_rows;
    assign o_cmd_ready = (!r_valid || i_ready) && !r_scroll_pend;
    assign o_valid = r_valid;
    assign o_data = r_data;
    assign o_last = r_last;

    always_comb begin
        logic [8:0] rr;
        w_c = (r_col >= w_w) ? w_w - 8'd1 : r_col;
        w_r = (r_row >= w_h) ? w_h - 8'd1 : r_row;
        w_emit = i_cmd.op != OP_LINE;
        w_nc = w_c;
        rr = {1'b0, w_r};
        w_c1 = {1'b0, w_c} + 9'd1;
        w_scroll = 1'b0;
        unique case (i_cmd.op)
            OP_LINE: begin w_nc = 8'd0; rr = rr + 9'd1; end
            OP_BACK: w_nc = (w_c != 8'd0) ? w_c - 8'd1 : 8'd0;
            default: begin
                if (w_c1 >= {1'b0, w_w}) begin w_nc = 8'd0; rr = rr + 9'd1; end
                else w_nc = w_c1[7:0];
            end
        endcase
        if (rr >= {1'b0, w_h}) begin
            w_scroll = 1'b1;
            w_nc = 8'd0;
            rr = {1'b0, w_h - 8'd1};
        end
        w_nr = rr[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_valid <= 1'b0;
            r_last <= 1'b0;
            r_scroll_pend <= 1'b0;
        end else begin
            if (i_cmd_valid && o_cmd_ready) begin
                r_col <= w_nc;
                r_row <= w_nr;
            end else if (i_item) begin
                r_col <= w_c;
                r_row <= w_r;
            end
            if (r_scroll_pend && (!r_valid || i_ready)) begin
                r_valid <= 1'b1;
                r_last <= 1'b1;
                r_data <= {{(TDATA_OUT_W-1){1'b0}}, 1'b1};
                r_scroll_pend <= 1'b0;
            end else if (i_cmd_valid && o_cmd_ready) begin
                if (w_emit) begin
                    r_valid <= 1'b1;
                    r_last <= !w_scroll;
                    r_data <= {7'd0, i_cmd.back, i_cmd.fore,
                               (i_cmd.op == OP_BACK) ? 8'd0 : i_cmd.code,
                               w_r, (i_cmd.op == OP_BACK) ? w_nc : w_c, 1'b0};
                    r_scroll_pend <= w_scroll;
                end else if (w_scroll) begin
                    r_valid <= 1'b1;
                    r_last <= 1'b1;
                    r_data <= {{(TDATA_OUT_W-1){1'b0}}, 1'b1};
                end else begin
                    r_valid <= 1'b0;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end
endmodule
